// ===== rtl/core/snf_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared command codes, phase codes, opcode table and the item, result and
// state structures used by the sequencer core and its step logic.
// ----------------------------------------------------------------------------
package snf_pkg;

   // Largest data transfer of one command, in bytes.
   localparam logic [8:0] PAGE_BYTES = 9'd256;

   // Item kinds on the request channel.
   localparam logic OP_START    = 1'b0;
   localparam logic OP_EXCHANGE = 1'b1;

   // Command codes.
   localparam logic [3:0] CMD_WREN         = 4'd0;
   localparam logic [3:0] CMD_ID           = 4'd1;
   localparam logic [3:0] CMD_STATUS       = 4'd2;
   localparam logic [3:0] CMD_WAIT_READY   = 4'd3;
   localparam logic [3:0] CMD_READ         = 4'd4;
   localparam logic [3:0] CMD_PROGRAM      = 4'd5;
   localparam logic [3:0] CMD_SECTOR_ERASE = 4'd6;
   localparam logic [3:0] CMD_BULK_ERASE   = 4'd7;
   localparam logic [3:0] CMD_POWER_DOWN   = 4'd8;
   localparam logic [3:0] CMD_WAKE         = 4'd9;
   localparam logic [3:0] CMD_LAST         = CMD_WAKE;

   // Flash opcodes.
   localparam logic [7:0] OPC_WREN         = 8'h06;
   localparam logic [7:0] OPC_READ_ID      = 8'h9F;
   localparam logic [7:0] OPC_READ_STATUS  = 8'h05;
   localparam logic [7:0] OPC_READ         = 8'h03;
   localparam logic [7:0] OPC_PROGRAM      = 8'h02;
   localparam logic [7:0] OPC_SECTOR_ERASE = 8'hD8;
   localparam logic [7:0] OPC_BULK_ERASE   = 8'hC7;
   localparam logic [7:0] OPC_POWER_DOWN   = 8'hB9;
   localparam logic [7:0] OPC_WAKE         = 8'hAB;
   localparam logic [7:0] DUMMY_BYTE       = 8'h00;

   // Status register write-in-progress bit.
   localparam int unsigned STATUS_WIP_BIT = 0;

   // Number of ID bytes reported after the ID opcode.
   localparam logic [8:0] ID_BYTES = 9'd3;

   // Sequencer phases.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_OPCODE = 3'd1;
   localparam logic [2:0] PH_ADDR   = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_READ   = 3'd4;

   typedef struct packed {
      logic        op;
      logic [3:0]  command;
      logic [23:0] flash_address;
      logic [8:0]  byte_count;
      logic [7:0]  received_byte;
      logic [7:0]  write_byte;
   } snf_item_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       select_active;
      logic       reselect;
      logic [7:0] read_byte;
      logic       read_valid;
      logic [7:0] last_status;
      logic       done_res;
      logic       misuse;
   } snf_result_type;

   typedef struct packed {
      logic [3:0]  active_command;
      logic [2:0]  phase;
      logic [8:0]  data_counter;
      logic [23:0] held_address;
      logic [8:0]  held_count;
      logic        busy;
      logic [7:0]  status_copy;
   } snf_state_type;

   // Opcode sent first for each command; unknown codes give zero.
   function automatic logic [7:0] opcode_of(input logic [3:0] cmd);
      logic [7:0] opc;
      unique case (cmd)
         CMD_WREN:         opc = OPC_WREN;
         CMD_ID:           opc = OPC_READ_ID;
         CMD_STATUS:       opc = OPC_READ_STATUS;
         CMD_WAIT_READY:   opc = OPC_READ_STATUS;
         CMD_READ:         opc = OPC_READ;
         CMD_PROGRAM:      opc = OPC_PROGRAM;
         CMD_SECTOR_ERASE: opc = OPC_SECTOR_ERASE;
         CMD_BULK_ERASE:   opc = OPC_BULK_ERASE;
         CMD_POWER_DOWN:   opc = OPC_POWER_DOWN;
         CMD_WAKE:         opc = OPC_WAKE;
         default:          opc = DUMMY_BYTE;
      endcase
      return opc;
   endfunction

endpackage

// ===== rtl/core/snf_step.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash sequencer step logic
// Combinational decision for one item: next sequencer state and the result.
// ----------------------------------------------------------------------------
module snf_step
   import snf_pkg::*;
(
   input  snf_item_type   item,
   input  snf_state_type  cur,
   output snf_state_type  nxt,
   output snf_result_type res
);

   logic [8:0] count_inc;
   logic [7:0] data_out;

   assign count_inc = cur.data_counter + 9'd1;
   assign data_out  = (cur.active_command == CMD_PROGRAM) ? item.write_byte : DUMMY_BYTE;

   always_comb begin
      nxt = cur;
      res = '0;

      if (item.op == OP_START) begin
         if (cur.busy) begin
            res.select_active = 1'b1;
            res.misuse        = 1'b1;
         end else if (item.command <= CMD_LAST) begin
            nxt.active_command = item.command;
            nxt.held_address   = item.flash_address;
            nxt.held_count     = (item.byte_count > PAGE_BYTES) ? PAGE_BYTES : item.byte_count;
            nxt.data_counter   = '0;
            nxt.busy           = 1'b1;
            nxt.phase          = PH_OPCODE;
            res.send_byte      = opcode_of(item.command);
            res.send_valid     = 1'b1;
            res.select_active  = 1'b1;
         end
      end else if (!cur.busy) begin
         res.misuse = 1'b1;
      end else begin
         // Every path below either sends a byte or releases select.
         res.send_valid    = 1'b1;
         res.select_active = 1'b1;
         res.done_res      = 1'b0;
         unique case (cur.phase)
            PH_OPCODE: begin
               unique case (cur.active_command) inside
                  CMD_ID, CMD_STATUS, CMD_WAIT_READY: begin
                     nxt.phase        = PH_READ;
                     nxt.data_counter = '0;
                     res.send_byte    = DUMMY_BYTE;
                  end
                  CMD_READ, CMD_PROGRAM, CMD_SECTOR_ERASE: begin
                     nxt.phase        = PH_ADDR;
                     nxt.data_counter = 9'd1;
                     res.send_byte    = cur.held_address[23:16];
                  end
                  default: begin
                     res.done_res = 1'b1;
                  end
               endcase
            end
            PH_ADDR: begin
               if (cur.data_counter == 9'd1) begin
                  nxt.data_counter = 9'd2;
                  res.send_byte    = cur.held_address[15:8];
               end else if (cur.data_counter == 9'd2) begin
                  nxt.data_counter = 9'd3;
                  res.send_byte    = cur.held_address[7:0];
               end else if (cur.active_command == CMD_SECTOR_ERASE ||
                            cur.held_count == 9'd0) begin
                  res.done_res = 1'b1;
               end else begin
                  nxt.phase        = PH_DATA;
                  nxt.data_counter = '0;
                  res.send_byte    = data_out;
               end
            end
            PH_DATA: begin
               if (cur.active_command == CMD_READ) begin
                  res.read_byte  = item.received_byte;
                  res.read_valid = 1'b1;
               end
               nxt.data_counter = count_inc;
               if (count_inc < cur.held_count) begin
                  res.send_byte = data_out;
               end else begin
                  res.done_res = 1'b1;
               end
            end
            PH_READ: begin
               res.read_byte  = item.received_byte;
               res.read_valid = 1'b1;
               if (cur.active_command == CMD_ID) begin
                  nxt.data_counter = count_inc;
                  if (count_inc < ID_BYTES) begin
                     res.send_byte = DUMMY_BYTE;
                  end else begin
                     res.done_res = 1'b1;
                  end
               end else begin
                  nxt.status_copy = item.received_byte;
                  if (cur.active_command == CMD_WAIT_READY &&
                      item.received_byte[STATUS_WIP_BIT]) begin
                     // Flash still busy: drop select and poll again.
                     nxt.phase        = PH_OPCODE;
                     nxt.data_counter = '0;
                     res.send_byte    = OPC_READ_STATUS;
                     res.reselect     = 1'b1;
                  end else begin
                     res.done_res = 1'b1;
                  end
               end
            end
            default: begin
               res.done_res = 1'b1;
            end
         endcase

         if (res.done_res) begin
            res.send_byte     = DUMMY_BYTE;
            res.send_valid    = 1'b0;
            res.select_active = 1'b0;
            nxt.busy          = 1'b0;
            nxt.phase         = PH_IDLE;
            nxt.data_counter  = '0;
         end
      end

      res.last_status = nxt.status_copy;
   end

endmodule

// ===== rtl/core/spi_nor_flash_command_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer core
// Each accepted item is held in the input register, then its step result is
// loaded into the result register once that register is free.
// Throughput: one item per cycle while results drain. If a result waits, one
// more item is taken into the input register, then req_ready drops until the
// waiting result leaves.
// Reset: synchronous, active high; the sequencer returns to idle, not busy,
// with zero status copy, and both registers are emptied.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_core
   import snf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [3:0]  req_command,
   input  logic [23:0] req_flash_address,
   input  logic [8:0]  req_byte_count,
   input  logic [7:0]  req_received_byte,
   input  logic [7:0]  req_write_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_send_valid,
   output logic        rsp_select_active,
   output logic        rsp_reselect,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic [7:0]  rsp_last_status,
   output logic        rsp_done_res,
   output logic        rsp_misuse
);

   // The input register captures each accepted item. The step logic then
   // decides on it using the sequencer state, and once the result register is
   // free the result is written into it, while the state registers advance.
   // Items are processed strictly in order, so each one sees the state that
   // its predecessor left behind.

   logic           s1_valid_ff, s1_valid_in;
   snf_item_type   s1_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   snf_result_type rsp_ff;
   snf_state_type  state_ff, state_in;
   snf_result_type step_res;
   snf_item_type   req_item;

   logic req_fire;
   logic step_fire;
   logic out_free;

   assign req_item = '{op:            req_op,
                       command:       req_command,
                       flash_address: req_flash_address,
                       byte_count:    req_byte_count,
                       received_byte: req_received_byte,
                       write_byte:    req_write_byte};

   // The result register is free when empty or when drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_fire = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || step_fire;
   assign req_fire  = req_valid && req_ready;

   snf_step u_step (
      .item (s1_item_ff),
      .cur  (state_ff),
      .nxt  (state_in),
      .res  (step_res)
   );

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (step_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (step_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{active_command: CMD_WREN,
                           phase:          PH_IDLE,
                           data_counter:   '0,
                           held_address:   '0,
                           held_count:     '0,
                           busy:           1'b0,
                           status_copy:    '0};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (step_fire) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_byte     = rsp_ff.send_byte;
   assign rsp_send_valid    = rsp_ff.send_valid;
   assign rsp_select_active = rsp_ff.select_active;
   assign rsp_reselect      = rsp_ff.reselect;
   assign rsp_read_byte     = rsp_ff.read_byte;
   assign rsp_read_valid    = rsp_ff.read_valid;
   assign rsp_last_status   = rsp_ff.last_status;
   assign rsp_done_res      = rsp_ff.done_res;
   assign rsp_misuse        = rsp_ff.misuse;

   // A finished command leaves the sequencer free for a new start.
   a_done_frees : assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_res.done_res) |=> !state_ff.busy)
      else $error("sequencer still busy after a completed command");

   // A reselect only happens while polling for ready, back at the opcode.
   a_reselect_poll : assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_res.reselect) |=>
         (state_ff.phase == PH_OPCODE && state_ff.active_command == CMD_WAIT_READY))
      else $error("reselect outside of wait-ready polling");

   // An idle sequencer always sits in the idle phase.
   a_idle_phase : assert property (@(posedge clock) disable iff (reset)
      !state_ff.busy |-> (state_ff.phase == PH_IDLE))
      else $error("phase not idle while sequencer is not busy");

   // A held item with a stalled result register blocks new items.
   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted while the input register cannot advance");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// Sends commands and byte completion items to the sequencer core, keeps its
// own copy of the sequencer state to predict each result, and checks every
// result against the prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import snf_pkg::*;

   // Run sizes and limits.
   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned RANDOM_ITEMS = 1050;
   localparam int unsigned STALL_LIMIT  = 4000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned MAX_REPORTS  = 10;

   // Command codes past the last defined one are ignored by an idle block.
   localparam logic [3:0] CMD_UNKNOWN_FIRST = CMD_LAST + 4'd1;
   localparam logic [3:0] CMD_UNKNOWN_TOP   = 4'hF;

   // Largest value the byte count field can carry.
   localparam logic [8:0] COUNT_FIELD_MAX = 9'h1FF;

   logic        clock = 1'b0;
   logic        reset;

   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [3:0]  req_command;
   logic [23:0] req_flash_address;
   logic [8:0]  req_byte_count;
   logic [7:0]  req_received_byte;
   logic [7:0]  req_write_byte;

   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_send_byte;
   logic        rsp_send_valid;
   logic        rsp_select_active;
   logic        rsp_reselect;
   logic [7:0]  rsp_read_byte;
   logic        rsp_read_valid;
   logic [7:0]  rsp_last_status;
   logic        rsp_done_res;
   logic        rsp_misuse;

   spi_nor_flash_command_sequencer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_command       (req_command),
      .req_flash_address (req_flash_address),
      .req_byte_count    (req_byte_count),
      .req_received_byte (req_received_byte),
      .req_write_byte    (req_write_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_send_byte     (rsp_send_byte),
      .rsp_send_valid    (rsp_send_valid),
      .rsp_select_active (rsp_select_active),
      .rsp_reselect      (rsp_reselect),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_last_status   (rsp_last_status),
      .rsp_done_res      (rsp_done_res),
      .rsp_misuse        (rsp_misuse)
   );

   // 10 ns clock: rising edges at 5, 15, 25 ns and so on.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Sequencer prediction
   // -------------------------------------------------------------------------
   // The testbench keeps its own copy of the sequencer state. Each accepted
   // item advances it and produces the result the block must return.
   logic [3:0]     seq_cmd;
   logic [2:0]     seq_phase;
   logic [8:0]     seq_index;
   logic [23:0]    seq_addr;
   logic [8:0]     seq_len;
   logic           seq_busy;
   logic [7:0]     seq_status;
   snf_result_type step_out;

   // Predicted results in the order the block must return them.
   snf_result_type predicted_steps[$];

   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches   = 0;

   // Idling is switched on and off per side, so that some stretches run at
   // full rate and others see gaps and stalls.
   bit req_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;

   // Opcode that opens each known command.
   function automatic logic [7:0] opcode_for(input logic [3:0] cmd);
      case (cmd)
         CMD_WREN:         return OPC_WREN;
         CMD_ID:           return OPC_READ_ID;
         CMD_STATUS:       return OPC_READ_STATUS;
         CMD_WAIT_READY:   return OPC_READ_STATUS;
         CMD_READ:         return OPC_READ;
         CMD_PROGRAM:      return OPC_PROGRAM;
         CMD_SECTOR_ERASE: return OPC_SECTOR_ERASE;
         CMD_BULK_ERASE:   return OPC_BULK_ERASE;
         CMD_POWER_DOWN:   return OPC_POWER_DOWN;
         default:          return OPC_WAKE;
      endcase
   endfunction

   // The next byte goes out with select held active.
   task put_byte(input logic [7:0] b);
      step_out.send_byte     = b;
      step_out.send_valid    = 1'b1;
      step_out.select_active = 1'b1;
   endtask

   // The command is complete: select is released and the sequencer idles.
   task end_frame;
      step_out.send_valid    = 1'b0;
      step_out.select_active = 1'b0;
      step_out.done_res      = 1'b1;
      seq_busy  = 1'b0;
      seq_phase = PH_IDLE;
      seq_index = '0;
   endtask

   // Advances the predicted state by one accepted item; the result is left
   // in step_out.
   task predict_step(input snf_item_type it);
      step_out = '0;
      if (it.op == OP_START) begin
         if (seq_busy) begin
            // A new command on top of a running one is refused; the running
            // frame keeps select asserted.
            step_out.select_active = 1'b1;
            step_out.misuse        = 1'b1;
         end else if (it.command <= CMD_LAST) begin
            seq_cmd   = it.command;
            seq_addr  = it.flash_address;
            seq_len   = (it.byte_count > PAGE_BYTES) ? PAGE_BYTES : it.byte_count;
            seq_index = '0;
            seq_busy  = 1'b1;
            seq_phase = PH_OPCODE;
            put_byte(opcode_for(it.command));
         end
         // Unknown command codes leave everything as it was.
      end else if (!seq_busy) begin
         step_out.misuse = 1'b1;
      end else begin
         case (seq_phase)
            PH_OPCODE: begin
               case (seq_cmd)
                  CMD_ID, CMD_STATUS, CMD_WAIT_READY: begin
                     seq_phase = PH_READ;
                     seq_index = '0;
                     put_byte(DUMMY_BYTE);
                  end
                  CMD_READ, CMD_PROGRAM, CMD_SECTOR_ERASE: begin
                     seq_phase = PH_ADDR;
                     seq_index = 9'd1;
                     put_byte(seq_addr[23:16]);
                  end
                  default: end_frame();
               endcase
            end
            PH_ADDR: begin
               // The index counts address bytes already issued.
               if (seq_index == 9'd1) begin
                  seq_index = 9'd2;
                  put_byte(seq_addr[15:8]);
               end else if (seq_index == 9'd2) begin
                  seq_index = 9'd3;
                  put_byte(seq_addr[7:0]);
               end else if (seq_cmd == CMD_SECTOR_ERASE || seq_len == '0) begin
                  end_frame();
               end else begin
                  seq_phase = PH_DATA;
                  seq_index = '0;
                  put_byte((seq_cmd == CMD_PROGRAM) ? it.write_byte : DUMMY_BYTE);
               end
            end
            PH_DATA: begin
               if (seq_cmd == CMD_READ) begin
                  step_out.read_byte  = it.received_byte;
                  step_out.read_valid = 1'b1;
               end
               seq_index = seq_index + 9'd1;
               if (seq_index < seq_len)
                  put_byte((seq_cmd == CMD_PROGRAM) ? it.write_byte : DUMMY_BYTE);
               else
                  end_frame();
            end
            PH_READ: begin
               step_out.read_byte  = it.received_byte;
               step_out.read_valid = 1'b1;
               if (seq_cmd == CMD_ID) begin
                  seq_index = seq_index + 9'd1;
                  if (seq_index < ID_BYTES)
                     put_byte(DUMMY_BYTE);
                  else
                     end_frame();
               end else begin
                  seq_status = it.received_byte;
                  if (seq_cmd == CMD_WAIT_READY && it.received_byte[STATUS_WIP_BIT]) begin
                     // Still writing: drop select and poll the status again.
                     seq_phase = PH_OPCODE;
                     seq_index = '0;
                     put_byte(OPC_READ_STATUS);
                     step_out.reselect = 1'b1;
                  end else begin
                     end_frame();
                  end
               end
            end
            default: end_frame();
         endcase
      end
      step_out.last_status = seq_status;
   endtask

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Gap length in cycles: mostly none or short, now and then long.
   function automatic int unsigned pick_gap(input bit enabled);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // Drives one item from a falling edge, holds it until the block takes it,
   // and records the predicted result at the accepting edge. Returns at the
   // falling edge after acceptance with valid still high, so that the next
   // item can follow without a gap.
   task send_item(input snf_item_type it);
      int unsigned gap;
      gap = pick_gap(req_idle_en);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op            = it.op;
      req_command       = it.command;
      req_flash_address = it.flash_address;
      req_byte_count    = it.byte_count;
      req_received_byte = it.received_byte;
      req_write_byte    = it.write_byte;
      req_valid         = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      predict_step(it);
      predicted_steps.push_back(step_out);
      @(negedge clock);
   endtask

   // Starts a command; the byte fields carry noise.
   task start_cmd(input logic [3:0] cmd, input logic [23:0] addr, input logic [8:0] count);
      snf_item_type it;
      it.op            = OP_START;
      it.command       = cmd;
      it.flash_address = addr;
      it.byte_count    = count;
      it.received_byte = 8'($urandom_range(0, 255));
      it.write_byte    = 8'($urandom_range(0, 255));
      send_item(it);
   endtask

   // Reports one finished byte exchange; the command fields carry noise.
   task complete_byte(input logic [7:0] rx, input logic [7:0] wb);
      snf_item_type it;
      it.op            = OP_EXCHANGE;
      it.command       = 4'($urandom_range(0, 15));
      it.flash_address = 24'($urandom_range(0, 24'hFFFFFF));
      it.byte_count    = 9'($urandom_range(0, 511));
      it.received_byte = rx;
      it.write_byte    = wb;
      send_item(it);
   endtask

   // Runs one command to its end with random bytes from the flash. With
   // intrude set, stray starts are thrown in while the command runs.
   task run_command(input logic [3:0] cmd, input logic [23:0] addr, input logic [8:0] count,
                    input bit intrude);
      start_cmd(cmd, addr, count);
      while (seq_busy) begin
         if (intrude && $urandom_range(0, 3) == 0)
            start_cmd(4'($urandom_range(0, 15)), 24'($urandom_range(0, 24'hFFFFFF)),
                      9'($urandom_range(0, 511)));
         else
            complete_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
   endtask

   // Data lengths: mostly a few bytes, sometimes dozens, rarely anything up
   // to the field maximum (which saturates at a page).
   function automatic logic [8:0] pick_count;
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 9'($urandom_range(0, 6));
      if (r < 95) return 9'($urandom_range(7, 40));
      return 9'($urandom_range(0, 511));
   endfunction

   // -------------------------------------------------------------------------
   // Result side
   // -------------------------------------------------------------------------
   // Ready is dropped for random stretches while stalling is enabled.
   initial begin : rsp_stall
      int unsigned hold;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0 && rsp_idle_en && $urandom_range(0, 3) == 0)
            hold = pick_gap(1'b1);
         if (hold > 0) begin
            hold--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("result %0d: %s expected 0x%02h, got 0x%02h",
                     results_seen, name, want, got);
      end
   endtask

   // Every accepted result is matched against the oldest prediction.
   always @(posedge clock) begin
      snf_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (predicted_steps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d arrived with no prediction pending", results_seen);
         end else begin
            want = predicted_steps.pop_front();
            check_field("send_byte",     want.send_byte,     rsp_send_byte);
            check_field("send_valid",    want.send_valid,    rsp_send_valid);
            check_field("select_active", want.select_active, rsp_select_active);
            check_field("reselect",      want.reselect,      rsp_reselect);
            check_field("read_byte",     want.read_byte,     rsp_read_byte);
            check_field("read_valid",    want.read_valid,    rsp_read_valid);
            check_field("last_status",   want.last_status,   rsp_last_status);
            check_field("done_res",      want.done_res,      rsp_done_res);
            check_field("misuse",        want.misuse,        rsp_misuse);
         end
      end
   end

   // The run is stopped if neither channel moves for too long.
   initial begin : watchdog
      int unsigned stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // A completion with no command running, and unknown command codes with
   // the address and count fields at their extremes.
   task test_idle_misuse;
      complete_byte(8'hFF, 8'h00);
      start_cmd(CMD_UNKNOWN_FIRST, 24'h000000, 9'd0);
      start_cmd(CMD_UNKNOWN_TOP, 24'hFFFFFF, COUNT_FIELD_MAX);
   endtask

   // Write enable is the opcode alone.
   task test_write_enable;
      start_cmd(CMD_WREN, 24'hFFFFFF, 9'd0);
      complete_byte(8'h00, 8'hFF);
   endtask

   // The byte received with the ID opcode is dropped; three ID bytes follow.
   task test_read_id;
      start_cmd(CMD_ID, 24'h000000, 9'd0);
      complete_byte(8'hAA, 8'h00);
      complete_byte(8'hFF, 8'h00);
      complete_byte(8'h00, 8'hFF);
      complete_byte(8'h5A, 8'h00);
   endtask

   // The first status poll shows a write in progress, so select is cycled
   // and the status read again. A start in between must be refused.
   task test_wait_ready_poll;
      start_cmd(CMD_WAIT_READY, 24'h123456, 9'd3);
      complete_byte(8'h00, 8'h00);
      complete_byte(8'h03, 8'h00);
      start_cmd(CMD_READ, 24'h000000, 9'd1);
      complete_byte(8'hFF, 8'h00);
      complete_byte(8'hFE, 8'h00);
   endtask

   // A read of zero bytes ends right after the last address byte.
   task test_read_no_data;
      start_cmd(CMD_READ, 24'hFFFFFF, 9'd0);
      while (seq_busy) complete_byte(8'hC3, 8'h3C);
   endtask

   // Program of a single byte at the lowest address.
   task test_program_one_byte;
      start_cmd(CMD_PROGRAM, 24'h000000, 9'd1);
      while (seq_busy) complete_byte(8'h00, 8'hFF);
   endtask

   // A full page read, and a program whose count saturates to a page.
   task test_full_page;
      run_command(CMD_READ, 24'($urandom_range(0, 24'hFFFFFF)), PAGE_BYTES, 1'b0);
      run_command(CMD_PROGRAM, 24'($urandom_range(0, 24'hFFFFFF)), COUNT_FIELD_MAX, 1'b0);
   endtask

   // Mostly complete commands with random content; the rest are unknown
   // codes, stray completions and commands with stray starts mixed in.
   task test_random_traffic;
      int unsigned first;
      int unsigned r;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) req_idle_en = ~req_idle_en;
         if ($urandom_range(0, 15) == 0) rsp_idle_en = ~rsp_idle_en;
         r = $urandom_range(0, 99);
         if (r < 85)
            run_command(4'($urandom_range(0, CMD_LAST)), 24'($urandom_range(0, 24'hFFFFFF)),
                        pick_count(), 1'b0);
         else if (r < 90)
            start_cmd(4'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_TOP)),
                      24'($urandom_range(0, 24'hFFFFFF)), 9'($urandom_range(0, 511)));
         else if (r < 95)
            complete_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         else
            run_command(4'($urandom_range(0, CMD_LAST)), 24'($urandom_range(0, 24'hFFFFFF)),
                        pick_count(), 1'b1);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_op            = OP_START;
      req_command       = CMD_WREN;
      req_flash_address = '0;
      req_byte_count    = '0;
      req_received_byte = '0;
      req_write_byte    = '0;

      // Predicted state matches the block after reset.
      seq_cmd    = CMD_WREN;
      seq_phase  = PH_IDLE;
      seq_index  = '0;
      seq_addr   = '0;
      seq_len    = '0;
      seq_busy   = 1'b0;
      seq_status = '0;

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      test_idle_misuse();
      test_write_enable();
      test_read_id();
      test_wait_ready_poll();
      test_read_no_data();
      test_program_one_byte();
      test_full_page();
      test_random_traffic();

      // Stop sending, let the result side run freely and collect what is
      // still owed, then keep watching for stray results to show up.
      req_valid   = 1'b0;
      rsp_idle_en = 1'b0;
      while (predicted_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && predicted_steps.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
